>>> rtl/core/bfba_pkg.sv
// bfba_pkg: shared types and constants of the best-fit block allocator
// no dependencies; used by bfba_cell and best_fit_block_allocator

package bfba_pkg;

   localparam int INDEX_W = 4;
   localparam int LIMIT_W = 5;

   localparam logic [LIMIT_W-1:0] IN_USE_RESET = 5'd16;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HOLD
   } state_type;

   // control part of the search word handed from cell to cell
   typedef struct packed {
      logic valid;
      logic have;
   } sweep_ctl_type;

endpackage

>>> rtl/core/best_fit_block_allocator.sv
// best_fit_block_allocator: top level, a chain of NUM_BLOCKS cells searched by a moving word
// depends on bfba_pkg and bfba_cell
// a request word walks the launch register, each cell stage and then the output register
// a new request is stalled until the result of the last one is loaded into the output register
// load words are taken only while idle and give no result
// reset: all blocks free, limit_ff = 16 (IN_USE_RESET), block sizes undefined until loaded

module best_fit_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [bfba_pkg::INDEX_W-1:0]         req_block_index,
   input  logic [SIZE_BITS-1:0]                 req_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [bfba_pkg::INDEX_W-1:0]         rsp_chosen_index,
   output logic [SIZE_BITS-1:0]                 rsp_chosen_size,
   output logic [SIZE_BITS-1:0]                 rsp_leftover,
   input  logic                                 csr_write_enable,
   input  logic [bfba_pkg::LIMIT_W-1:0]         csr_write_data
);

   localparam int IDX_BITS = $clog2(NUM_BLOCKS);

   bfba_pkg::state_type            state_ff;
   bfba_pkg::state_type            state_in;
   logic [bfba_pkg::LIMIT_W-1:0]   limit_ff;

   logic                           req_accept;
   logic                           load_en;
   logic                           launch_valid_ff;
   logic [SIZE_BITS-1:0]           launch_size_ff;

   bfba_pkg::sweep_ctl_type        link_ctl   [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0]           link_req   [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0]           link_size  [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0]           link_left  [NUM_BLOCKS+1];
   logic [IDX_BITS-1:0]            link_idx   [NUM_BLOCKS+1];
   logic [NUM_BLOCKS-1:0]          stage_valid;

   logic                           hold_have_ff;
   logic [SIZE_BITS-1:0]           hold_size_ff;
   logic [SIZE_BITS-1:0]           hold_left_ff;
   logic [IDX_BITS-1:0]            hold_idx_ff;

   logic                           out_free;
   logic                           out_load;
   logic                           hold_load;
   logic                           sel_have;
   logic [SIZE_BITS-1:0]           sel_size;
   logic [SIZE_BITS-1:0]           sel_left;
   logic [IDX_BITS-1:0]            sel_idx;
   logic                           grant_en;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_found_ff;
   logic [bfba_pkg::INDEX_W-1:0]   rsp_index_ff;
   logic [SIZE_BITS-1:0]           rsp_size_ff;
   logic [SIZE_BITS-1:0]           rsp_left_ff;

   assign req_stall  = (state_ff != bfba_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_en    = req_accept && (req_func == bfba_pkg::FUNC_LOAD);

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bfba_pkg::IN_USE_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // launch stage feeding cell 0
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_valid_ff <= 1'b0;
      end else begin
         launch_valid_ff <= req_accept && (req_func == bfba_pkg::FUNC_REQUEST);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         launch_size_ff <= req_size;
      end
   end

   assign link_ctl[0].valid = launch_valid_ff;
   assign link_ctl[0].have  = 1'b0;
   assign link_req[0]       = launch_size_ff;
   assign link_size[0]      = '0;
   assign link_left[0]      = '0;
   assign link_idx[0]       = '0;

   for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      bfba_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_BITS  (IDX_BITS),
         .CELL_IDX  (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .load_en       (load_en),
         .load_index    (req_block_index),
         .load_size     (req_size),
         .grant_en      (grant_en),
         .grant_index   (sel_idx),
         .limit         (limit_ff),
         .in_ctl        (link_ctl[g]),
         .in_req_size   (link_req[g]),
         .in_best_size  (link_size[g]),
         .in_best_left  (link_left[g]),
         .in_best_idx   (link_idx[g]),
         .out_ctl       (link_ctl[g+1]),
         .out_req_size  (link_req[g+1]),
         .out_best_size (link_size[g+1]),
         .out_best_left (link_left[g+1]),
         .out_best_idx  (link_idx[g+1])
      );
      assign stage_valid[g] = link_ctl[g+1].valid;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      out_load  = 1'b0;
      hold_load = 1'b0;
      sel_have  = link_ctl[NUM_BLOCKS].have;
      sel_size  = link_size[NUM_BLOCKS];
      sel_left  = link_left[NUM_BLOCKS];
      sel_idx   = link_idx[NUM_BLOCKS];
      unique case (state_ff)
         bfba_pkg::ST_IDLE: begin
            if (req_accept && (req_func == bfba_pkg::FUNC_REQUEST)) begin
               state_in = bfba_pkg::ST_SEARCH;
            end
         end
         bfba_pkg::ST_SEARCH: begin
            if (link_ctl[NUM_BLOCKS].valid) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = bfba_pkg::ST_IDLE;
               end else begin
                  hold_load = 1'b1;
                  state_in  = bfba_pkg::ST_HOLD;
               end
            end
         end
         bfba_pkg::ST_HOLD: begin
            sel_have = hold_have_ff;
            sel_size = hold_size_ff;
            sel_left = hold_left_ff;
            sel_idx  = hold_idx_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = bfba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfba_pkg::ST_IDLE;
         end
      endcase
   end

   assign grant_en = out_load && sel_have;

   always_ff @(posedge clock) begin
      if (hold_load) begin
         hold_have_ff <= link_ctl[NUM_BLOCKS].have;
         hold_size_ff <= link_size[NUM_BLOCKS];
         hold_left_ff <= link_left[NUM_BLOCKS];
         hold_idx_ff  <= link_idx[NUM_BLOCKS];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_found_ff <= sel_have;
         rsp_index_ff <= bfba_pkg::INDEX_W'(sel_idx);
         rsp_size_ff  <= sel_size;
         rsp_left_ff  <= sel_left;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_chosen_size  = rsp_size_ff;
   assign rsp_leftover     = rsp_left_ff;

   // only one search word in the chain
   a_one_word : assert property (@(posedge clock) disable iff (reset)
      $onehot0(stage_valid))
      else $error("more than one search word in the cell chain");

   a_end_in_search : assert property (@(posedge clock) disable iff (reset)
      link_ctl[NUM_BLOCKS].valid |-> state_ff == bfba_pkg::ST_SEARCH)
      else $error("search word left the chain outside the search state");

   a_request_starts : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == bfba_pkg::FUNC_REQUEST)) |=> launch_valid_ff)
      else $error("accepted request did not enter the chain");

   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) != bfba_pkg::ST_IDLE)
      else $error("result word appeared without a search");

   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_index_ff == '0) && (rsp_size_ff == '0) && (rsp_left_ff == '0))
      else $error("not-found result carries nonzero fields");

endmodule

>>> rtl/core/bfba_cell.sv
// bfba_cell: one table entry (size and used mark) plus one stage of the search chain
// depends on bfba_pkg

module bfba_cell #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_BITS  = 4,
   parameter int CELL_IDX  = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_en,
   input  logic [bfba_pkg::INDEX_W-1:0]   load_index,
   input  logic [SIZE_BITS-1:0]           load_size,
   input  logic                           grant_en,
   input  logic [IDX_BITS-1:0]            grant_index,
   input  logic [bfba_pkg::LIMIT_W-1:0]   limit,
   input  bfba_pkg::sweep_ctl_type        in_ctl,
   input  logic [SIZE_BITS-1:0]           in_req_size,
   input  logic [SIZE_BITS-1:0]           in_best_size,
   input  logic [SIZE_BITS-1:0]           in_best_left,
   input  logic [IDX_BITS-1:0]            in_best_idx,
   output bfba_pkg::sweep_ctl_type        out_ctl,
   output logic [SIZE_BITS-1:0]           out_req_size,
   output logic [SIZE_BITS-1:0]           out_best_size,
   output logic [SIZE_BITS-1:0]           out_best_left,
   output logic [IDX_BITS-1:0]            out_best_idx
);

   logic [SIZE_BITS-1:0]    size_ff;
   logic                    used_ff;
   logic                    used_in;
   logic                    load_hit;
   logic                    grant_hit;
   logic                    in_range;
   logic                    fits;
   logic                    better;
   logic [SIZE_BITS-1:0]    left;

   bfba_pkg::sweep_ctl_type ctl_ff;
   bfba_pkg::sweep_ctl_type ctl_in;
   logic [SIZE_BITS-1:0]    req_size_ff;
   logic [SIZE_BITS-1:0]    best_size_ff;
   logic [SIZE_BITS-1:0]    best_size_in;
   logic [SIZE_BITS-1:0]    best_left_ff;
   logic [SIZE_BITS-1:0]    best_left_in;
   logic [IDX_BITS-1:0]     best_idx_ff;
   logic [IDX_BITS-1:0]     best_idx_in;

   assign load_hit  = load_en && (int'(load_index) == CELL_IDX);
   assign grant_hit = grant_en && (int'(grant_index) == CELL_IDX);
   assign in_range  = CELL_IDX < int'(limit);
   assign left      = size_ff - in_req_size;
   assign fits      = in_ctl.valid && !used_ff && in_range && (size_ff >= in_req_size);
   assign better    = fits && (!in_ctl.have || (left < in_best_left));

   always_comb begin
      used_in = used_ff;
      if (load_hit) begin
         used_in = 1'b0;
      end else if (grant_hit) begin
         used_in = 1'b1;
      end
      ctl_in.valid = in_ctl.valid;
      ctl_in.have  = in_ctl.have || fits;
      best_size_in = in_best_size;
      best_left_in = in_best_left;
      best_idx_in  = in_best_idx;
      if (better) begin
         best_size_in = size_ff;
         best_left_in = left;
         best_idx_in  = IDX_BITS'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         used_ff <= used_in;
         ctl_ff  <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         size_ff <= load_size;
      end
      req_size_ff  <= in_req_size;
      best_size_ff <= best_size_in;
      best_left_ff <= best_left_in;
      best_idx_ff  <= best_idx_in;
   end

   assign out_ctl       = ctl_ff;
   assign out_req_size  = req_size_ff;
   assign out_best_size = best_size_ff;
   assign out_best_left = best_left_ff;
   assign out_best_idx  = best_idx_ff;

endmodule
